FILE: sv/p2_orientation_autocorrelation_unit_defines.svh
// assertion macros for the p2 orientation autocorrelation unit
// used by the top level; expects signals named clock and reset in scope
`ifndef P2_ORIENTATION_AUTOCORRELATION_UNIT_DEFINES_SVH
`define P2_ORIENTATION_AUTOCORRELATION_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define P2AC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define P2AC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/p2ac_pkg.sv
// shared types and constants of the p2 orientation autocorrelation unit
// no dependencies
package p2ac_pkg;

   localparam int MAX_LAG     = 64;
   localparam int LAG_BITS    = 6;
   localparam int NLAG_BITS   = 7;
   localparam int MAX_SAMPLES = 65536;
   localparam int CNT_BITS    = 17;
   localparam int COMP_BITS   = 16;
   localparam int VEC_BITS    = 3 * COMP_BITS;
   localparam int ACC_BITS    = 48;
   localparam int LIM_BITS    = 7;
   localparam int NUM_BITS    = 96;
   localparam int DEN_BITS    = 64;
   localparam int QUO_BITS    = 32;
   localparam int HALF_SHIFT  = 29;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] vec_x;
      logic signed [COMP_BITS-1:0] vec_y;
      logic signed [COMP_BITS-1:0] vec_z;
      logic                        series_end;
   } req_type;

   typedef struct packed {
      logic [LAG_BITS-1:0] lag;
      logic signed [31:0]  corr_value;
      logic                degenerate;
      logic                last_result;
   } rsp_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic                busy;
      logic                done;
      logic [QUO_BITS-1:0] quot;
   } div_rsp_type;

endpackage

FILE: sv/p2ac_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module p2ac_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/p2ac_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit 32 bits
// depends on p2ac_pkg
module p2ac_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [p2ac_pkg::NUM_BITS-1:0] num,
   input  logic [p2ac_pkg::DEN_BITS-1:0] den,
   output p2ac_pkg::div_rsp_type         status
);

   logic [p2ac_pkg::NUM_BITS-1:0] rem_ff, rem_in;
   logic [p2ac_pkg::NUM_BITS-1:0] dsh_ff, dsh_in;
   logic [p2ac_pkg::QUO_BITS-1:0] quot_ff, quot_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          ge;

   // one compare and subtract per step
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ge      = (rem_ff >= dsh_ff);
      if (start) begin
         rem_in  = num;
         dsh_in  = {{(p2ac_pkg::NUM_BITS - p2ac_pkg::DEN_BITS){1'b0}}, den}
                   << (p2ac_pkg::QUO_BITS - 1);
         quot_in = '0;
         cnt_in  = 5'(p2ac_pkg::QUO_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[p2ac_pkg::QUO_BITS-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.quot = quot_ff;

endmodule

FILE: sv/p2_orientation_autocorrelation_unit.sv
// top level of the p2 orientation autocorrelation unit
// depends on p2ac_pkg, p2ac_ram, p2ac_div and the assertion header
//
// Each accepted vector is stored in a 64-entry history ram and paired with
// itself and up to 63 predecessors; every pair reads the history ram, forms
// dot product and norms one component a cycle, squares, multiplies the norms
// and runs a 32-step shared divider before adding its term to the lag
// accumulator ram. A vector therefore stalls the input until its span + 1
// pairs are done, span = min(count, 63), and forms none once count reaches
// 65536; a pair with a zero vector skips the divider and the accumulator.
// On the vector marked series_end, state S_OCALC works out the lag count,
// then one result per lag goes through the same divider, each waiting out
// any output stall; the series state clears as the last result is loaded.
// Accumulator entries are cleared by per-entry valid bits, so no clearing
// pass is needed after reset. The lag_limit register may be written at any
// time while the unit is idle.
`include "p2_orientation_autocorrelation_unit_defines.svh"

module p2_orientation_autocorrelation_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  p2ac_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output p2ac_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [p2ac_pkg::LIM_BITS-1:0]     csr_wdata
);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_RD    = 14'b00000000000010,
      S_MAC   = 14'b00000000000100,
      S_SQ    = 14'b00000000001000,
      S_DEN   = 14'b00000000010000,
      S_DST   = 14'b00000000100000,
      S_DIV   = 14'b00000001000000,
      S_ACC   = 14'b00000010000000,
      S_NEXT  = 14'b00000100000000,
      S_OCALC = 14'b00001000000000,
      S_ORD   = 14'b00010000000000,
      S_OWT   = 14'b00100000000000,
      S_ODIV  = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   localparam int LB = p2ac_pkg::LAG_BITS;
   localparam int CB = p2ac_pkg::COMP_BITS;
   localparam int AB = p2ac_pkg::ACC_BITS;

   state_type state_ff, state_in;

   logic [p2ac_pkg::LIM_BITS-1:0]  lim_ff;
   logic [p2ac_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic                           zero_ff, zero_in;
   logic [LB-1:0]                  head_ff, head_in;
   logic [LB-1:0]                  lag_ff, lag_in;
   logic [LB-1:0]                  span_ff, span_in;
   logic [p2ac_pkg::NLAG_BITS-1:0] n_ff, n_in;
   logic                           end_ff, end_in;
   logic [1:0]                     comp_ff, comp_in;
   logic signed [CB-1:0]           ax_ff, ay_ff, az_ff;
   logic signed [32:0]             dot_ff, dot_in;
   logic [31:0]                    nb_ff, nb_in;
   logic [31:0]                    na_ff, na_in;
   logic [63:0]                    sq_ff, sq_in;
   logic [63:0]                    den_ff, den_in;
   logic                           pz_ff, pz_in;
   logic signed [31:0]             term_ff, term_in;
   logic                           neg_ff, neg_in;
   logic [p2ac_pkg::MAX_LAG-1:0]   vld_ff, vld_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   p2ac_pkg::rsp_type              rsp_ff, rsp_in;

   logic                           accept;
   logic [p2ac_pkg::VEC_BITS-1:0]  hist_rdata;
   logic                           hist_rd;
   logic [LB-1:0]                  hist_raddr;
   logic                           acc_rd, acc_wr;
   logic [LB-1:0]                  acc_raddr;
   logic [AB-1:0]                  acc_rdata, acc_wdata;
   logic signed [AB-1:0]           acc_cur;
   logic                           div_start;
   logic [p2ac_pkg::NUM_BITS-1:0]  div_num;
   logic [p2ac_pkg::DEN_BITS-1:0]  div_den;
   p2ac_pkg::div_rsp_type          div_status;
   logic signed [CB-1:0]           a_c, b_c;
   logic signed [31:0]             pab, pbb;
   logic [31:0]                    ad, na_sel;
   logic [65:0]                    sq3;
   logic [AB-1:0]                  acc_mag;
   logic [p2ac_pkg::CNT_BITS-1:0]  divisor;
   logic [31:0]                    qval;
   logic                           rsp_last_load;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // history ram: one vector per entry, circular at head
   p2ac_ram #(.WIDTH(p2ac_pkg::VEC_BITS), .DEPTH(p2ac_pkg::MAX_LAG)) u_hist (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (head_ff),
      .wr_data ({req_data.vec_z, req_data.vec_y, req_data.vec_x}),
      .rd_en   (hist_rd),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   // lag accumulator ram, cleared through valid bits
   p2ac_ram #(.WIDTH(AB), .DEPTH(p2ac_pkg::MAX_LAG)) u_acc (
      .clock   (clock),
      .wr_en   (acc_wr),
      .wr_addr (lag_ff),
      .wr_data (acc_wdata),
      .rd_en   (acc_rd),
      .rd_addr (acc_raddr),
      .rd_data (acc_rdata)
   );

   p2ac_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_status)
   );

   // component select for the serial dot product
   always_comb begin
      case (comp_ff)
         2'd0: begin
            a_c = ax_ff;
            b_c = hist_rdata[CB-1:0];
         end
         2'd1: begin
            a_c = ay_ff;
            b_c = hist_rdata[2*CB-1:CB];
         end
         default: begin
            a_c = az_ff;
            b_c = hist_rdata[3*CB-1:2*CB];
         end
      endcase
   end

   assign pab     = a_c * b_c;
   assign pbb     = b_c * b_c;
   assign ad      = dot_ff[32] ? 32'(-dot_ff) : dot_ff[31:0];
   assign na_sel  = (lag_ff == '0) ? nb_ff : na_ff;
   assign sq3     = {sq_ff, 1'b0} + {2'b00, sq_ff};
   assign acc_cur = vld_ff[lag_ff] ? signed'(acc_rdata) : '0;
   assign acc_mag = acc_cur[AB-1] ? AB'(-acc_cur) : AB'(acc_cur);
   assign divisor = count_ff - p2ac_pkg::CNT_BITS'(lag_ff);
   assign qval    = div_status.quot;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      zero_in      = zero_ff;
      head_in      = head_ff;
      lag_in       = lag_ff;
      span_in      = span_ff;
      n_in         = n_ff;
      end_in       = end_ff;
      comp_in      = comp_ff;
      dot_in       = dot_ff;
      nb_in        = nb_ff;
      na_in        = na_ff;
      sq_in        = sq_ff;
      den_in       = den_ff;
      pz_in        = pz_ff;
      term_in      = term_ff;
      neg_in       = neg_ff;
      vld_in       = vld_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      hist_rd      = 1'b0;
      hist_raddr   = head_ff - lag_ff;
      acc_rd       = 1'b0;
      acc_raddr    = lag_ff;
      acc_wr       = 1'b0;
      acc_wdata    = AB'(acc_cur + AB'(term_ff));
      div_start    = 1'b0;
      div_num      = {{(p2ac_pkg::NUM_BITS - $bits(sq3) - p2ac_pkg::HALF_SHIFT){1'b0}},
                      sq3, {p2ac_pkg::HALF_SHIFT{1'b0}}};
      div_den      = den_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               end_in = req_data.series_end;
               lag_in = '0;
               span_in = (count_ff < p2ac_pkg::CNT_BITS'(p2ac_pkg::MAX_LAG - 1))
                         ? count_ff[LB-1:0] : LB'(p2ac_pkg::MAX_LAG - 1);
               if (count_ff < p2ac_pkg::CNT_BITS'(p2ac_pkg::MAX_SAMPLES)) begin
                  state_in = S_RD;
               end else if (req_data.series_end) begin
                  state_in = S_OCALC;
               end
            end
         end
         S_RD: begin
            hist_rd  = 1'b1;
            comp_in  = 2'd0;
            dot_in   = '0;
            nb_in    = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            dot_in  = dot_ff + 33'(pab);
            nb_in   = nb_ff + 32'(pbb);
            comp_in = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            sq_in = ad * ad;
            if (lag_ff == '0) begin
               na_in = nb_ff;
            end
            acc_rd   = 1'b1;
            state_in = S_DEN;
         end
         S_DEN: begin
            den_in   = na_sel * nb_ff;
            pz_in    = (na_sel == '0) || (nb_ff == '0);
            state_in = S_DST;
         end
         S_DST: begin
            if (pz_ff) begin
               zero_in  = 1'b1;
               state_in = S_NEXT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               term_in  = signed'(qval - 32'(1 << p2ac_pkg::HALF_SHIFT));
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_wr          = 1'b1;
            vld_in[lag_ff]  = 1'b1;
            state_in        = S_NEXT;
         end
         S_NEXT: begin
            if (lag_ff == span_ff) begin
               head_in  = head_ff + LB'(1);
               count_in = count_ff + p2ac_pkg::CNT_BITS'(1);
               state_in = end_ff ? S_OCALC : S_IDLE;
            end else begin
               lag_in   = lag_ff + LB'(1);
               state_in = S_RD;
            end
         end
         S_OCALC: begin
            lag_in = '0;
            n_in   = (count_ff < p2ac_pkg::CNT_BITS'(p2ac_pkg::MAX_LAG))
                     ? count_ff[p2ac_pkg::NLAG_BITS-1:0]
                     : p2ac_pkg::NLAG_BITS'(p2ac_pkg::MAX_LAG);
            if (lim_ff != '0 && p2ac_pkg::CNT_BITS'(lim_ff) <= count_ff) begin
               n_in = (lim_ff < p2ac_pkg::LIM_BITS'(p2ac_pkg::MAX_LAG))
                      ? lim_ff : p2ac_pkg::NLAG_BITS'(p2ac_pkg::MAX_LAG);
            end
            state_in = S_ORD;
            if (count_ff == '0) begin
               vld_in   = '0;
               zero_in  = 1'b0;
               head_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_ORD: begin
            acc_rd   = 1'b1;
            state_in = S_OWT;
         end
         S_OWT: begin
            div_start = 1'b1;
            div_num   = p2ac_pkg::NUM_BITS'(acc_mag);
            div_den   = p2ac_pkg::DEN_BITS'(divisor);
            neg_in    = acc_cur[AB-1];
            state_in  = S_ODIV;
         end
         S_ODIV: begin
            if (div_status.done) begin
               term_in  = neg_ff ? signed'(-qval) : signed'(qval);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.lag         = lag_ff;
               rsp_in.corr_value  = term_ff;
               rsp_in.degenerate  = zero_ff;
               rsp_in.last_result = (p2ac_pkg::NLAG_BITS'(lag_ff) + 7'd1 == n_ff);
               if (p2ac_pkg::NLAG_BITS'(lag_ff) + 7'd1 == n_ff) begin
                  vld_in   = '0;
                  count_in = '0;
                  zero_in  = 1'b0;
                  head_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  lag_in   = lag_ff + LB'(1);
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lim_ff       <= '0;
         count_ff     <= '0;
         zero_ff      <= 1'b0;
         head_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         zero_ff      <= zero_in;
         head_ff      <= head_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            lim_ff <= csr_wdata;
         end
      end
      if (accept) begin
         ax_ff <= req_data.vec_x;
         ay_ff <= req_data.vec_y;
         az_ff <= req_data.vec_z;
      end
      lag_ff  <= lag_in;
      span_ff <= span_in;
      n_ff    <= n_in;
      end_ff  <= end_in;
      comp_ff <= comp_in;
      dot_ff  <= dot_in;
      nb_ff   <= nb_in;
      na_ff   <= na_in;
      sq_ff   <= sq_in;
      den_ff  <= den_in;
      pz_ff   <= pz_in;
      term_ff <= term_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   // last result of a series being loaded into the output register
   assign rsp_last_load = rsp_valid_in && !(rsp_valid_ff && rsp_stall) && rsp_in.last_result;

   // checks
   `P2AC_ASSERT_NOW(a_div_idle_start, div_start, !div_status.busy, "divider restarted while busy")
   `P2AC_ASSERT_NOW(a_no_zero_acc, acc_wr, !pz_ff, "degenerate pair written to accumulator")
   `P2AC_ASSERT_NEXT(a_last_clears, rsp_last_load, count_ff == '0, "series state not cleared")

endmodule
